[hdl/adtd_pkg.sv]
// shared types, constants and the month length table for the date adder
// no dependencies
package adtd_pkg;

  // field widths
  localparam int YearW    = 14;
  localparam int MonthW   = 4;
  localparam int DayW     = 5;
  localparam int AddW     = 16;
  localparam int StatusW  = 2;
  localparam int TotalW   = 17;
  localparam int InDataW  = 40;
  localparam int OutDataW = 32;

  // calendar constants
  localparam logic [YearW-1:0]  YEAR_LIMIT  = 14'd9999;
  localparam logic [YearW-1:0]  CYCLE_YEARS = 14'd400;
  localparam logic [YearW-1:0]  CYCLE_LAST  = 14'd399;
  localparam logic [YearW-1:0]  CENTURY_1   = 14'd100;
  localparam logic [YearW-1:0]  CENTURY_2   = 14'd200;
  localparam logic [YearW-1:0]  CENTURY_3   = 14'd300;
  localparam logic [MonthW-1:0] MONTH_FIRST = 4'd1;
  localparam logic [MonthW-1:0] MONTH_FEB   = 4'd2;
  localparam logic [MonthW-1:0] MONTH_LAST  = 4'd12;
  localparam logic [DayW-1:0]   DAYS_FEB_LEAP = 5'd29;
  localparam logic [DayW-1:0]   DAYS_FEB      = 5'd28;
  localparam logic [DayW-1:0]   DAYS_SHORT    = 5'd30;
  localparam logic [DayW-1:0]   DAYS_LONG     = 5'd31;

  // result status codes
  typedef enum logic [StatusW-1:0] {
    ST_OK        = 2'd0,
    ST_BAD_MONTH = 2'd1,
    ST_OVERFLOW  = 2'd2
  } status_t;

  // sequencer states
  typedef enum logic [2:0] {
    S_IDLE,
    S_MOD,
    S_SUM,
    S_WALK,
    S_DONE
  } state_t;

  // shared adder operation
  typedef enum logic {
    ALU_ADD,
    ALU_SUB
  } alu_op_t;

  // adder result flags
  typedef struct packed {
    logic [TotalW-1:0] res;
    logic              borrow;
    logic              zero;
  } alu_res_t;

  // days in month m (1..12), leap selects 29 for february
  function automatic logic [DayW-1:0] days_in(input logic [MonthW-1:0] m, input logic leap);
    logic [DayW-1:0] len;
    len = DAYS_LONG;
    case (m) inside
      MONTH_FEB:             len = leap ? DAYS_FEB_LEAP : DAYS_FEB;
      4'd4, 4'd6, 4'd9, 4'd11: len = DAYS_SHORT;
      default:               len = DAYS_LONG;
    endcase
    return len;
  endfunction

endpackage

[hdl/add_days_to_date_unit.sv]
// date plus day count: top level with sequencer, working registers and output register
// depends on adtd_pkg and adtd_alu
//
//  channel | dir | handshake          | payload
//  s_      | in  | s_tvalid/s_tready  | s_tdata: start date and day count
//  m_      | out | m_tvalid/m_tready  | m_tdata: result date and status
//
// after a request is taken: S_MOD reduces the year modulo 400 (Y = year / 400, 0..24),
// S_SUM adds the lengths of the M = month - 1 earlier months, S_WALK subtracts one month
// length each (W months walked, about 2160 for the largest count), then S_DONE loads the
// output register and m_tvalid rises.
// every step goes through the one shared adder; a walk that runs past 9999 ends on its
// last subtraction, and a bad month or a start year past 9999 goes straight to done.
// rst is synchronous and clears the sequencer and the output valid flag.
// a result waiting on m_tready holds; the next request is taken meanwhile and waits in done.
module add_days_to_date_unit (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            s_tvalid,
  output logic                            s_tready,
  // [13:0] start_year, [17:14] start_month, [22:18] start_day, [38:23] days_to_add
  input  logic [adtd_pkg::InDataW-1:0]    s_tdata,
  output logic                            m_tvalid,
  input  logic                            m_tready,
  // [13:0] result_year, [17:14] result_month, [22:18] result_day, [24:23] status
  output logic [adtd_pkg::OutDataW-1:0]   m_tdata
);
  import adtd_pkg::*;

  state_t             state, state_next;
  logic [YearW-1:0]   year;
  logic [YearW-1:0]   yrem;
  logic [MonthW-1:0]  mon;
  logic [MonthW-1:0]  m;
  logic [TotalW-1:0]  total;
  status_t            status;
  logic               out_valid;
  logic [OutDataW-1:0] out_data;

  logic [YearW-1:0]   in_year;
  logic [MonthW-1:0]  in_month;
  logic [DayW-1:0]    in_day;
  logic [AddW-1:0]    in_add;
  logic               accept;
  logic               bad_month;
  logic               big_year;
  logic               leap;
  logic [DayW-1:0]    len;
  logic               fits;
  logic               load_out;

  alu_op_t            alu_op;
  logic [TotalW-1:0]  alu_a;
  logic [TotalW-1:0]  alu_b;
  alu_res_t           alu_out;

  // unpack request
  assign in_year   = s_tdata[13:0];
  assign in_month  = s_tdata[17:14];
  assign in_day    = s_tdata[22:18];
  assign in_add    = s_tdata[38:23];
  assign accept    = s_tvalid && s_tready;
  assign bad_month = (in_month < MONTH_FIRST) || (in_month > MONTH_LAST);
  assign big_year  = in_year > YEAR_LIMIT;

  // leap rule on the year modulo 400
  assign leap = (yrem[1:0] == 2'b00) && (yrem != CENTURY_1) && (yrem != CENTURY_2)
                && (yrem != CENTURY_3);
  assign len  = days_in(m, leap);

  // operand select for the shared adder
  always_comb begin
    alu_op = ALU_ADD;
    alu_a  = total;
    alu_b  = {{(TotalW-DayW){1'b0}}, len};
    unique case (state)
      S_MOD: begin
        alu_op = ALU_SUB;
        alu_a  = {{(TotalW-YearW){1'b0}}, yrem};
        alu_b  = {{(TotalW-YearW){1'b0}}, CYCLE_YEARS};
      end
      S_WALK: begin
        alu_op = ALU_SUB;
      end
      default: begin
        alu_op = ALU_ADD;
      end
    endcase
  end

  adtd_alu u_alu (
    .op     (alu_op),
    .a      (alu_a),
    .b      (alu_b),
    .result (alu_out)
  );

  // remainder fits in the current month
  assign fits = alu_out.borrow || alu_out.zero;

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (accept) begin
          state_next = (bad_month || big_year) ? S_DONE : S_MOD;
        end
      end
      S_MOD: begin
        if (alu_out.borrow) state_next = S_SUM;
      end
      S_SUM: begin
        if (m == mon) state_next = S_WALK;
      end
      S_WALK: begin
        if (fits || ((m == MONTH_LAST) && (year == YEAR_LIMIT))) state_next = S_DONE;
      end
      S_DONE: begin
        if (load_out) state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  // handshake outputs
  always_comb begin
    s_tready = (state == S_IDLE);
    load_out = (state == S_DONE) && (!out_valid || m_tready);
  end

  // sequencer state
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // working registers
  always_ff @(posedge clk) begin
    unique case (state)
      S_IDLE: begin
        if (accept) begin
          year   <= in_year;
          yrem   <= in_year;
          mon    <= in_month;
          m      <= MONTH_FIRST;
          total  <= {{(TotalW-DayW){1'b0}}, in_day} + {{(TotalW-AddW){1'b0}}, in_add};
          status <= ST_OK;
          if (bad_month) begin
            status <= ST_BAD_MONTH;
            year   <= '0;
            m      <= '0;
            total  <= '0;
          end else if (big_year) begin
            status <= ST_OVERFLOW;
            year   <= YEAR_LIMIT;
            m      <= MONTH_LAST;
            total  <= {{(TotalW-DayW){1'b0}}, DAYS_LONG};
          end
        end
      end
      S_MOD: begin
        if (!alu_out.borrow) yrem <= alu_out.res[YearW-1:0];
      end
      S_SUM: begin
        if (m != mon) begin
          total <= alu_out.res;
          m     <= m + MonthW'(1);
        end else begin
          m <= MONTH_FIRST;
        end
      end
      S_WALK: begin
        if (!fits) begin
          total <= alu_out.res;
          if (m == MONTH_LAST) begin
            m <= MONTH_FIRST;
            if (year == YEAR_LIMIT) begin
              status <= ST_OVERFLOW;
              m      <= MONTH_LAST;
              total  <= {{(TotalW-DayW){1'b0}}, DAYS_LONG};
            end else begin
              year <= year + YearW'(1);
              yrem <= (yrem == CYCLE_LAST) ? '0 : yrem + YearW'(1);
            end
          end else begin
            m <= m + MonthW'(1);
          end
        end
      end
      default: begin
      end
    endcase
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load_out) begin
      out_valid <= 1'b1;
    end else if (m_tready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      out_data <= {{(OutDataW-YearW-MonthW-DayW-StatusW){1'b0}}, status, total[DayW-1:0],
                   m, year};
    end
  end

  assign m_tvalid = out_valid;
  assign m_tdata  = out_data;

endmodule

[hdl/adtd_alu.sv]
// shared add/subtract unit used by every step of the date sequencer
// depends on adtd_pkg
module adtd_alu (
  input  adtd_pkg::alu_op_t               op,
  input  logic [adtd_pkg::TotalW-1:0]     a,
  input  logic [adtd_pkg::TotalW-1:0]     b,
  output adtd_pkg::alu_res_t              result
);
  import adtd_pkg::*;

  logic [TotalW:0] wide;

  // one adder, b inverted for subtract, top bit is the borrow
  always_comb begin
    if (op == ALU_SUB) begin
      wide = {1'b0, a} - {1'b0, b};
    end else begin
      wide = {1'b0, a} + {1'b0, b};
    end
    result.res    = wide[TotalW-1:0];
    result.borrow = (op == ALU_SUB) ? wide[TotalW] : 1'b0;
    result.zero   = (wide[TotalW-1:0] == '0);
  end

endmodule

[hdl/adtd_checker.sv]
// port-level checks for the date adder, bound to the top level
// depends on adtd_pkg and add_days_to_date_unit
module adtd_checker (
  input logic                            clk,
  input logic                            rst,
  input logic                            s_tvalid,
  input logic                            s_tready,
  input logic                            m_tvalid,
  input logic                            m_tready,
  input logic [adtd_pkg::OutDataW-1:0]   m_tdata
);
  import adtd_pkg::*;

  // a stalled result holds
  assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
    else $error("result changed while stalled");

  // one request at a time: busy right after a request
  assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready |=> !s_tready)
    else $error("request taken while busy");

  // bad month gives an all-zero date
  assert property (@(posedge clk) disable iff (rst)
    m_tvalid && (m_tdata[24:23] == ST_BAD_MONTH) |-> (m_tdata[22:0] == '0))
    else $error("bad month result not cleared");

  // overflow saturates, good results stay in range
  assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> ((m_tdata[24:23] == ST_OVERFLOW) && (m_tdata[13:0] == YEAR_LIMIT)
                  && (m_tdata[17:14] == MONTH_LAST) && (m_tdata[22:18] == DAYS_LONG))
              || ((m_tdata[24:23] == ST_OK) && (m_tdata[13:0] <= YEAR_LIMIT)
                  && (m_tdata[17:14] >= MONTH_FIRST) && (m_tdata[17:14] <= MONTH_LAST))
              || (m_tdata[24:23] == ST_BAD_MONTH))
    else $error("result out of range");

endmodule

bind add_days_to_date_unit adtd_checker u_adtd_checker (.*);

[dv/add_days_to_date_checker.sv]
// result checker for the date adder: predicts each date from the accepted request
// and compares every result field; depends on adtd_pkg
module add_days_to_date_checker
  import adtd_pkg::*;
(
  input  logic                clk,
  input  logic                rst,
  input  logic                s_tvalid,
  input  logic                s_tready,
  input  logic [InDataW-1:0]  s_tdata,
  input  logic                m_tvalid,
  input  logic                m_tready,
  input  logic [OutDataW-1:0] m_tdata,
  output int                  mismatch_count,
  output int                  dates_waiting
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [YearW-1:0]  year;
    logic [MonthW-1:0] month;
    logic [DayW-1:0]   day;
    status_t           status;
  } date_t;

  date_t expected_dates[$];

  // gregorian rule: every 4th year, but not centuries unless divisible by 400
  function automatic bit is_leap(input int unsigned yr);
    return ((yr % 4 == 0) && (yr % 100 != 0)) || (yr % 400 == 0);
  endfunction

  function automatic int unsigned month_len(input int unsigned yr, input int unsigned mo);
    case (mo)
      2:           return is_leap(yr) ? 29 : 28;
      4, 6, 9, 11: return 30;
      default:     return 31;
    endcase
  endfunction

  // date reached after adding the day count to the requested start date
  function automatic date_t advance_date(input logic [InDataW-1:0] req);
    date_t       res;
    int unsigned yr, mo, remaining, k;
    yr        = req[YearW-1:0];
    mo        = req[YearW +: MonthW];
    remaining = req[YearW+MonthW +: DayW] + req[YearW+MonthW+DayW +: AddW];
    res       = '{year: '0, month: '0, day: '0, status: ST_BAD_MONTH};
    if (mo < MONTH_FIRST || mo > MONTH_LAST) return res;
    // saturated date, used for any overflow past the last year
    res = '{year: YEAR_LIMIT, month: MONTH_LAST, day: DAYS_LONG, status: ST_OVERFLOW};
    if (yr > YEAR_LIMIT) return res;
    // ordinal within the start year; day is not checked against month length
    for (k = 1; k < mo; k++) remaining += month_len(yr, k);
    // walk forward a month at a time from january of the start year
    mo = 1;
    while (remaining > month_len(yr, mo)) begin
      remaining -= month_len(yr, mo);
      mo++;
      if (mo > MONTH_LAST) begin
        mo = 1;
        yr++;
        if (yr > YEAR_LIMIT) return res;
      end
    end
    res.year   = YearW'(yr);
    res.month  = MonthW'(mo);
    res.day    = DayW'(remaining);
    res.status = ST_OK;
    return res;
  endfunction

  task automatic flag_error(input string msg);
    if (mismatch_count < 10) $display("[%0t] date check: %s", $realtime, msg);
    mismatch_count++;
  endtask

  // results are compared before new requests are queued, so an early result is caught
  always @(posedge clk) begin
    date_t got, want;
    if (!rst) begin
      if (m_tvalid && m_tready) begin
        got.year   = m_tdata[YearW-1:0];
        got.month  = m_tdata[YearW +: MonthW];
        got.day    = m_tdata[YearW+MonthW +: DayW];
        got.status = status_t'(m_tdata[YearW+MonthW+DayW +: StatusW]);
        if (expected_dates.size() == 0) begin
          flag_error($sformatf("result %0d-%0d-%0d status %0d with no request waiting",
                               got.year, got.month, got.day, got.status));
        end else begin
          want = expected_dates.pop_front();
          if (got.year !== want.year || got.month !== want.month ||
              got.day !== want.day || got.status !== want.status) begin
            flag_error($sformatf("expected %0d-%0d-%0d status %0d, got %0d-%0d-%0d status %0d",
                                 want.year, want.month, want.day, want.status,
                                 got.year, got.month, got.day, got.status));
          end
        end
      end
      if (s_tvalid && s_tready) expected_dates.push_back(advance_date(s_tdata));
    end
    dates_waiting <= expected_dates.size();
  end

endmodule

[dv/add_days_to_date_unit_tb.sv]
// top of the date adder testbench: clock, reset, request and result handshakes, verdict
// depends on adtd_pkg, add_days_to_date_unit and add_days_to_date_checker
module add_days_to_date_unit_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import adtd_pkg::*;

  localparam int ClkHalf       = 6;
  localparam int ResetCycles   = 5;
  localparam int RandomDates   = 246;
  localparam int HoldOffAt     = 40;
  localparam int HoldOffCycles = 400;
  localparam int DrainCycles   = 2300;
  localparam int CycleLimit    = 3_000_000;

  logic                clk      = 1'b0;
  logic                rst      = 1'b1;
  logic                s_tvalid = 1'b0;
  logic                s_tready;
  logic [InDataW-1:0]  s_tdata  = '0;
  logic                m_tvalid;
  logic                m_tready = 1'b0;
  logic [OutDataW-1:0] m_tdata;
  int                  mismatch_count;
  int                  dates_waiting;
  int                  cycle_count = 0;
  int                  send_calm   = 0;
  int                  take_calm   = 0;

  add_days_to_date_unit DUT (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

  add_days_to_date_checker date_check (
    .clk            (clk),
    .rst            (rst),
    .s_tvalid       (s_tvalid),
    .s_tready       (s_tready),
    .s_tdata        (s_tdata),
    .m_tvalid       (m_tvalid),
    .m_tready       (m_tready),
    .m_tdata        (m_tdata),
    .mismatch_count (mismatch_count),
    .dates_waiting  (dates_waiting)
  );

  initial begin : clock_gen
    forever #ClkHalf clk = ~clk;
  end

  // idle cycles before the next handshake, with occasional runs of back-to-back traffic
  function automatic int pick_idle(inout int calm_left);
    if (calm_left > 0) begin
      calm_left--;
      return 0;
    end
    if ($urandom_range(0, 15) == 0) begin
      calm_left = $urandom_range(8, 30);
      return 0;
    end
    return $urandom_range(0, 13);
  endfunction

  // present one request and hold it until the block takes it
  task automatic offer_date(input logic [YearW-1:0] yr, input logic [MonthW-1:0] mo,
                            input logic [DayW-1:0] dy, input logic [AddW-1:0] count);
    int gap;
    gap = pick_idle(send_calm);
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= {{(InDataW-YearW-MonthW-DayW-AddW){1'b0}}, count, dy, mo, yr};
    @(posedge clk);
    while (!s_tready) @(posedge clk);
  endtask

  // result side, with one long hold-off so the block backs up into its input
  initial begin : result_sink
    int gap;
    int taken;
    taken = 0;
    wait (!rst);
    forever begin
      gap = pick_idle(take_calm);
      if (taken == HoldOffAt) gap = HoldOffCycles;
      if (gap > 0) begin
        m_tready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      m_tready <= 1'b1;
      @(posedge clk);
      while (!m_tvalid) @(posedge clk);
      taken++;
    end
  end

  initial begin : watchdog
    while (cycle_count < CycleLimit) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("== FAIL ==");
    $finish;
  end

  initial begin : stimulus
    int                pick;
    int                i;
    int                k;
    logic [YearW-1:0]  yr;
    logic [MonthW-1:0] mo;
    logic [DayW-1:0]   dy;
    logic [AddW-1:0]   count;

    repeat (ResetCycles) @(posedge clk);
    rst <= 1'b0;

    // extremes of every field
    offer_date(14'd1,     4'd1,  5'd1,  16'd0);
    offer_date(14'd9999,  4'd12, 5'd31, 16'd0);
    offer_date(14'd9999,  4'd12, 5'd31, 16'd1);
    offer_date(14'd1,     4'd1,  5'd1,  16'd65535);
    offer_date(14'd9999,  4'd1,  5'd1,  16'd65535);
    // start year already past the limit, and a bad month taking precedence over it
    offer_date(14'd16383, 4'd1,  5'd1,  16'd0);
    offer_date(14'd16383, 4'd0,  5'd31, 16'd65535);
    offer_date(14'd2000,  4'd15, 5'd1,  16'd0);
    // year zero counts as leap
    offer_date(14'd0,     4'd2,  5'd28, 16'd1);
    // day zero and a day beyond the month length
    offer_date(14'd2000,  4'd1,  5'd0,  16'd0);
    offer_date(14'd2021,  4'd2,  5'd31, 16'd0);
    // century rule and year rollover
    offer_date(14'd1900,  4'd2,  5'd28, 16'd1);
    offer_date(14'd2000,  4'd2,  5'd28, 16'd1);
    offer_date(14'd2023,  4'd12, 5'd31, 16'd1);
    // exactly the last date, and one day past the last date
    offer_date(14'd9999,  4'd12, 5'd1,  16'd30);
    offer_date(14'd9999,  4'd12, 5'd1,  16'd31);
    // the remaining start months
    for (k = 3; k <= 11; k++) begin
      offer_date(14'($urandom_range(1, 9999)), MonthW'(k), 5'd28, AddW'(k * 37));
    end

    // random dates: mostly valid starts with short counts, some long counts,
    // some close to the last year, and a share of arbitrary field values
    for (i = 0; i < RandomDates; i++) begin
      pick  = $urandom_range(0, 99);
      yr    = 14'($urandom_range(1, 9999));
      mo    = MonthW'($urandom_range(MONTH_FIRST, MONTH_LAST));
      dy    = 5'($urandom_range(1, 31));
      count = 16'($urandom_range(0, 1500));
      if (pick < 8) begin
        yr    = 14'($urandom);
        mo    = 4'($urandom);
        dy    = 5'($urandom);
        count = 16'($urandom);
      end else if (pick < 14) begin
        count = 16'($urandom);
      end else if (pick < 24) begin
        yr    = 14'($urandom_range(9985, 9999));
        count = 16'($urandom_range(0, 6000));
      end
      offer_date(yr, mo, dy, count);
    end
    s_tvalid <= 1'b0;

    // let the last result come out, then watch a while for anything extra
    @(posedge clk);
    while (dates_waiting != 0) @(posedge clk);
    repeat (DrainCycles) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
